[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the command line framer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define CLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define CLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/clf_pkg.sv]
// ---------------------------------------------------------------------------
// Command line framer package
// Ring sizing, character codes, status and operation codes, helpers.
// ---------------------------------------------------------------------------
package clf_pkg;

  localparam int RING_DEPTH  = 512;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int CNT_W       = PTR_W + 1;
  localparam int MAX_CMD_LEN = 64;
  localparam int END_W       = $clog2(MAX_CMD_LEN);
  localparam int LEN_W       = 7;
  localparam int CMP_W       = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_CMD_LEN);

  localparam logic OP_PUSH    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic REG_CMD_BUF_LEN = 1'b0;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;
  localparam logic [7:0] CHAR_UA = 8'h41;
  localparam logic [7:0] CHAR_UZ = 8'h5A;
  localparam logic [7:0] CHAR_LA = 8'h61;
  localparam logic [7:0] CHAR_LZ = 8'h7A;

  typedef enum logic [1:0] {
    ST_NONE         = 2'd0,
    ST_CHAR         = 2'd1,
    ST_TOO_LONG     = 2'd2,
    ST_FULL_CLEARED = 2'd3
  } status_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return c inside {[CHAR_0:CHAR_9], [CHAR_UA:CHAR_UZ], [CHAR_LA:CHAR_LZ]};
  endfunction

  function automatic logic is_term(input logic [7:0] c);
    return c inside {CHAR_CR, CHAR_LF};
  endfunction

  // Ring index arithmetic; the offset never exceeds the depth.
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = {2'b00, base} + {1'b0, ofs};
    if (sum >= (CNT_W+1)'(RING_DEPTH)) begin
      sum = sum - (CNT_W+1)'(RING_DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

[hw/rtl/clf_channels.sv]
// ---------------------------------------------------------------------------
// Command line framer channels
// Valid/ready interfaces for the input and result streams.
// ---------------------------------------------------------------------------
interface clf_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output rx_byte, input ready);
  modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

interface clf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] cmd_char;
  logic       last;

  modport source (output valid, output status, output cmd_char, output last, input ready);
  modport sink (input valid, input status, input cmd_char, input last, output ready);
endinterface

[hw/rtl/clf_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module clf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[hw/rtl/clf_cfg.sv]
// ---------------------------------------------------------------------------
// Command line framer configuration
// APB-style register holding the caller's command buffer length.
// ---------------------------------------------------------------------------
module clf_cfg import clf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output logic [LEN_W-1:0]  cmd_buf_len
);

  logic [LEN_W-1:0] len_r;
  logic             wr_en;

  assign pready      = 1'b1;
  assign wr_en       = psel && penable && pwrite && pready && (paddr[2] == REG_CMD_BUF_LEN);
  assign prdata      = (paddr[2] == REG_CMD_BUF_LEN) ? DATA_W'(len_r) : '0;
  assign cmd_buf_len = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (wr_en) begin
      len_r <= pwdata[LEN_W-1:0];
    end
  end

endmodule

[hw/rtl/clf_seq.sv]
// ---------------------------------------------------------------------------
// Command line framer sequencer
// Walks the ring through one shared index adder to strip, scan and emit.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module clf_seq import clf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  clf_in_if.sink           in_ch,
  clf_out_if.source        out_ch,
  input  logic [LEN_W-1:0] cmd_buf_len,
  output logic             ram_we,
  output logic             ram_re,
  output logic [PTR_W-1:0] ram_addr,
  input  logic [7:0]       ram_rdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_STRIP_RD, S_STRIP_CHK, S_SCAN_RD, S_SCAN_CHK,
    S_EMIT_RD, S_EMIT_LD, S_DROP, S_RES
  } state_t;

  state_t           state_r, state_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [END_W-1:0] end_r, end_nxt;
  status_t          res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  logic [CNT_W-1:0] ofs;
  logic [PTR_W-1:0] ring_sum;
  logic             out_free;
  logic             full;
  logic [LEN_W-1:0] lim;
  logic             emit_last;

  assign full      = (fill_r == CNT_W'(RING_DEPTH));
  assign out_free  = !out_valid_r || out_ch.ready;
  assign lim       = (cmd_buf_len > LEN_W'(MAX_CMD_LEN)) ? LEN_W'(MAX_CMD_LEN) : cmd_buf_len;
  assign emit_last = (CMP_W'(idx_r) + CMP_W'(1)) == CMP_W'(end_r);

  always_comb begin
    case (state_r)
      S_IDLE:      ofs = fill_r;
      S_STRIP_RD:  ofs = '0;
      S_STRIP_CHK: ofs = CNT_W'(1);
      S_DROP:      ofs = CNT_W'(end_r);
      default:     ofs = idx_r;
    endcase
  end

  assign ring_sum = ring_add(rp_r, ofs);
  assign ram_addr = ring_sum;
  assign ram_we   = (state_r == S_IDLE) && in_ch.valid && (in_ch.operation == OP_PUSH) && !full;
  assign ram_re   = (state_r == S_STRIP_RD) || (state_r == S_SCAN_RD) || (state_r == S_EMIT_RD);

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_status_r;
  assign out_ch.cmd_char = out_char_r;
  assign out_ch.last     = out_last_r;

  always_comb begin
    state_nxt      = state_r;
    rp_nxt         = rp_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    end_nxt        = end_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.operation == OP_REQUEST) begin
            state_nxt = S_STRIP_RD;
          end else if (!full) begin
            fill_nxt = fill_r + CNT_W'(1);
          end
        end
      end
      S_STRIP_RD: begin
        if (fill_r == '0) begin
          idx_nxt   = CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_STRIP_CHK;
        end
      end
      S_STRIP_CHK: begin
        if (is_alnum(ram_rdata)) begin
          idx_nxt   = CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end else begin
          rp_nxt    = ring_sum;
          fill_nxt  = fill_r - CNT_W'(1);
          state_nxt = S_STRIP_RD;
        end
      end
      S_SCAN_RD: begin
        if (idx_r >= fill_r) begin
          if (full) begin
            rp_nxt   = '0;
            fill_nxt = '0;
            res_nxt  = ST_FULL_CLEARED;
          end else begin
            res_nxt = ST_NONE;
          end
          state_nxt = S_RES;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!is_term(ram_rdata)) begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end else if (CMP_W'(idx_r) >= CMP_W'(lim)) begin
          rp_nxt    = ring_sum;
          fill_nxt  = fill_r - idx_r;
          res_nxt   = ST_TOO_LONG;
          state_nxt = S_RES;
        end else begin
          end_nxt   = END_W'(idx_r);
          idx_nxt   = '0;
          state_nxt = S_EMIT_RD;
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_CHAR;
          out_char_nxt   = ram_rdata;
          out_last_nxt   = emit_last;
          idx_nxt        = idx_r + CNT_W'(1);
          state_nxt      = emit_last ? S_DROP : S_EMIT_RD;
        end
      end
      S_DROP: begin
        rp_nxt    = ring_sum;
        fill_nxt  = fill_r - CNT_W'(end_r);
        state_nxt = S_IDLE;
      end
      S_RES: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_r;
          out_char_nxt   = 8'h00;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r        <= idx_nxt;
    end_r        <= end_nxt;
    res_r        <= res_nxt;
    out_status_r <= out_status_nxt;
    out_char_r   <= out_char_nxt;
    out_last_r   <= out_last_nxt;
  end

  `CLF_ASSERT(a_fill_bound, fill_r <= CNT_W'(RING_DEPTH), "Fill count exceeds the ring depth")
  `CLF_ASSERT(a_push_count, (state_r == S_IDLE && in_ch.valid && in_ch.operation == OP_PUSH && !full) |=> (fill_r == $past(fill_r) + CNT_W'(1)), "Accepted push did not grow the ring")
  `CLF_ASSERT(a_status_item, (out_valid_r && out_status_r != ST_CHAR) |-> (out_char_r == 8'h00 && out_last_r), "Status result carries a character or is not last")
  `CLF_ASSERT(a_end_fits, (state_r == S_EMIT_LD) |-> (CMP_W'(idx_r) < CMP_W'(end_r)), "Emission ran past the line end")
  `CLF_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (!out_valid_r && state_r == S_IDLE), "Reset left a result pending")

endmodule

[hw/rtl/command_line_framer_unit.sv]
// Pushes are taken while the sequencer is idle and may then follow each other in every cycle.
// A request walks s stripped bytes, n scanned bytes and e emitted characters, each
// costing one registered read of the ring RAM, whose read and write ports share one address.
// Emission also waits for the result register to drain; one result is held there.
// Reset is synchronous and active low: the ring becomes empty and the length register
// returns to 64. No clearing pass is needed, as only data from written ring entries is used.
// ---------------------------------------------------------------------------
// Command line framer unit
// Ring-buffered receiver that frames CR/LF terminated command lines on request.
// ---------------------------------------------------------------------------
module command_line_framer_unit import clf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  clf_in_if.sink            in_ch,
  clf_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [LEN_W-1:0] cmd_buf_len;
  logic             ram_we;
  logic             ram_re;
  logic [PTR_W-1:0] ram_addr;
  logic [7:0]       ram_rdata;

  clf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cmd_buf_len (cmd_buf_len)
  );

  clf_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cmd_buf_len (cmd_buf_len),
    .ram_we      (ram_we),
    .ram_re      (ram_re),
    .ram_addr    (ram_addr),
    .ram_rdata   (ram_rdata)
  );

  clf_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (in_ch.rx_byte),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

endmodule
